/* rtl/core/wsfd_pkg.sv */
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsfd_pkg;

  // Parse phases of the frame header and payload.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTHI   = 3'd2,
    PH_EXTLO   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  // Frame status codes reported at the end of each frame.
  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_CLOSE    = 3'd1,
    ST_PING     = 3'd2,
    ST_PONG     = 3'd3,
    ST_BAD_OP   = 3'd4,
    ST_LEN64    = 3'd5,
    ST_TOO_LONG = 3'd6
  } status_e;

  // Opcodes of interest.
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Seven-bit length codes that announce extended lengths.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Number of mask key bytes.
  localparam logic [15:0] MASK_BYTES = 16'd4;

  // Width of the buffer limit register and its reset value.
  localparam int unsigned LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // One result item.
  typedef struct packed {
    logic [7:0]  data;
    logic        has_data;
    logic        frame_end;
    status_e     status;
    logic [15:0] frame_len;
  } result_t;

  // Maps an opcode to the status reported at the end of its frame.
  function automatic status_e status_of_opcode(input logic [3:0] op);
    status_e st;
    case (op)
      OP_TEXT, OP_BINARY: st = ST_DATA;
      OP_CLOSE:           st = ST_CLOSE;
      OP_PING:            st = ST_PING;
      OP_PONG:            st = ST_PONG;
      default:            st = ST_BAD_OP;
    endcase
    return st;
  endfunction

endpackage

/* rtl/core/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer: one received byte per transfer.
// Each byte passes the input register, and its result the result register.
// Throughput: one byte per cycle, set by the single parse step between the
// input register and the result register; stalls only under output backpressure.
// Reset: asynchronous, active low; parsing restarts at the first header byte
// and the buffer limit returns to 65536.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_o,
  output logic        has_data_o,
  output logic        frame_end_o,
  output logic [2:0]  status_o,
  output logic [15:0] frame_len_o
);

  logic [wsfd_pkg::LIMIT_W-1:0] limit_q;
  logic                         s1_valid;
  logic [7:0]                   s1_byte;
  logic                         step;
  logic                         res_valid;
  wsfd_pkg::result_t            res;
  wsfd_pkg::result_t            out_res;

  // Buffer limit register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wsfd_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // The held byte is parsed when the result register can take its result.
  assign step = s1_valid && (!out_valid_o || out_ready_i);

  wsfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (step),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign data_o      = out_res.data;
  assign has_data_o  = out_res.has_data;
  assign frame_end_o = out_res.frame_end;
  assign status_o    = out_res.status;
  assign frame_len_o = out_res.frame_len;

endmodule

/* rtl/core/wsfd_in_reg.sv */
// Input register stage holding one received byte ahead of the parser.
module wsfd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The stage takes a new byte when empty or when its byte moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/core/wsfd_parser.sv */
// Frame parser: header state, mask key and per-byte result decode.
module wsfd_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   byte_i,
  input  logic [wsfd_pkg::LIMIT_W-1:0] limit_i,
  output logic                         res_valid_o,
  output wsfd_pkg::result_t            res_o
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]       opcode_q, opcode_d;
  logic             masked_q, masked_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      count_q, count_d;
  logic [31:0]      key_q, key_d;

  logic        len_known;
  logic        hdr_done;
  logic        masked_now;
  logic [15:0] len_sel;
  logic [15:0] count_inc;
  logic [7:0]  key_byte;

  assign count_inc = count_q + 16'd1;

  // Mask key byte for the current payload index, first key byte at the top.
  always_comb begin
    case (count_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    masked_d    = masked_q;
    len_d       = len_q;
    count_d     = count_q;
    key_d       = key_q;
    len_known   = 1'b0;
    hdr_done    = 1'b0;
    masked_now  = masked_q;
    len_sel     = len_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      wsfd_pkg::PH_HDR0: begin
        opcode_d = byte_i[3:0];
        phase_d  = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        masked_d   = byte_i[7];
        masked_now = byte_i[7];
        key_d      = '0;
        if (byte_i[6:0] == wsfd_pkg::LEN_EXT64) begin
          res_valid_o     = 1'b1;
          res_o.frame_end = 1'b1;
          res_o.status    = wsfd_pkg::ST_LEN64;
          phase_d         = wsfd_pkg::PH_HDR0;
        end else if (byte_i[6:0] == wsfd_pkg::LEN_EXT16) begin
          phase_d = wsfd_pkg::PH_EXTHI;
        end else begin
          len_d     = {9'd0, byte_i[6:0]};
          len_sel   = {9'd0, byte_i[6:0]};
          len_known = 1'b1;
        end
      end
      wsfd_pkg::PH_EXTHI: begin
        len_d   = {byte_i, 8'h00};
        phase_d = wsfd_pkg::PH_EXTLO;
      end
      wsfd_pkg::PH_EXTLO: begin
        len_d     = {len_q[15:8], byte_i};
        len_sel   = {len_q[15:8], byte_i};
        len_known = 1'b1;
      end
      wsfd_pkg::PH_MASK: begin
        key_d   = {key_q[23:0], byte_i};
        count_d = count_inc;
        if (count_inc >= wsfd_pkg::MASK_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        res_valid_o    = 1'b1;
        res_o.data     = byte_i ^ key_byte;
        res_o.has_data = 1'b1;
        count_d        = count_inc;
        if (count_inc >= len_q) begin
          res_o.frame_end = 1'b1;
          res_o.status    = wsfd_pkg::status_of_opcode(opcode_q);
          res_o.frame_len = len_q;
          phase_d         = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_d = wsfd_pkg::PH_HDR0;
      end
    endcase

    // Length is known: collect the mask key first if there is one.
    if (len_known) begin
      count_d = '0;
      if (masked_now) begin
        phase_d = wsfd_pkg::PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: check the length limit, then an empty payload.
    if (hdr_done) begin
      if ({1'b0, len_sel} >= limit_i) begin
        res_valid_o     = 1'b1;
        res_o.frame_end = 1'b1;
        res_o.status    = wsfd_pkg::ST_TOO_LONG;
        res_o.frame_len = len_sel;
        phase_d         = wsfd_pkg::PH_HDR0;
      end else begin
        count_d = '0;
        if (len_sel == 16'd0) begin
          res_valid_o     = 1'b1;
          res_o.frame_end = 1'b1;
          res_o.status    = wsfd_pkg::status_of_opcode(opcode_q);
          phase_d         = wsfd_pkg::PH_HDR0;
        end else begin
          phase_d = wsfd_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  // Parser state advances only when a byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_HDR0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      count_q  <= '0;
      key_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      count_q  <= count_d;
      key_q    <= key_d;
    end
  end

endmodule

/* rtl/core/wsfd_out_reg.sv */
// Result register that holds one result until its transfer completes.
module wsfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              res_valid_i,
  input  wsfd_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wsfd_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  wsfd_pkg::result_t res_q;

  // A step only happens when the register is empty or being emptied.
  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = res_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
